// File: rtl/jeag_pkg.sv
package jeag_pkg;

  localparam int VALUE_WIDTH = 24;
  localparam int LIMIT_WIDTH = 23;
  localparam int TIME_WIDTH  = 32;
  localparam int SUSP_WIDTH  = 16;
  localparam int DIR_WIDTH   = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLIFY_FRACTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VELOCITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSPENSION_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT      = 3'd6;

  // Direction modes
  localparam logic [DIR_WIDTH-1:0] DIR_BOTH      = 2'd0;
  localparam logic [DIR_WIDTH-1:0] DIR_FLEX_ONLY = 2'd1;
  localparam logic [DIR_WIDTH-1:0] DIR_EXT_ONLY  = 2'd2;
  localparam logic [DIR_WIDTH-1:0] DIR_NONE      = 2'd3;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] velocity;
    logic        [TIME_WIDTH-1:0]  now_ms;
    logic signed [VALUE_WIDTH-1:0] trajectory_position;
    logic signed [VALUE_WIDTH-1:0] present_position;
  } tick_in_t;

  typedef struct packed {
    logic                          torque_on;
    logic                          drive_setup;
    logic                          goal_write;
    logic signed [VALUE_WIDTH-1:0] goal_position;
  } tick_out_t;

endpackage

// File: rtl/joint_effort_amplify_gate_core.sv
// Flow: a beat accepted into the input register is evaluated into the result register
//   once that is free, and is then offered on the output.
// Throughput: one beat per cycle while results drain; a stalled result holds the input
//   register, so the input stalls once both stages are full.
// Reset: asynchronous, active low; empties both stages, clears the joint state and the
//   registers (direction extension, first movement pending, torque off, all times zero).
module joint_effort_amplify_gate_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  jeag_pkg::tick_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output jeag_pkg::tick_out_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [jeag_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jeag_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int VW   = jeag_pkg::VALUE_WIDTH;
  localparam int LW   = jeag_pkg::LIMIT_WIDTH;
  localparam int TW   = jeag_pkg::TIME_WIDTH;
  localparam int CmpW = ((VW > FRAC_BITS + 3) ? VW : FRAC_BITS + 3) + 2;
  localparam logic signed [CmpW-1:0] Five = CmpW'(5) << FRAC_BITS;

  // configuration
  logic [jeag_pkg::DIR_WIDTH-1:0]  dir_mode_q;
  logic [LW-1:0]                   start_vel_q, max_vel_q, upper_q, lower_q;
  logic [jeag_pkg::SUSP_WIDTH-1:0] susp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_mode_q  <= jeag_pkg::DIR_BOTH;
      start_vel_q <= '0;
      max_vel_q   <= '0;
      susp_q      <= '0;
      upper_q     <= '0;
      lower_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        jeag_pkg::CFG_DIRECTION_MODE: dir_mode_q  <= cfg_data_i[jeag_pkg::DIR_WIDTH-1:0];
        jeag_pkg::CFG_START_VELOCITY: start_vel_q <= cfg_data_i[LW-1:0];
        jeag_pkg::CFG_MAX_VELOCITY:   max_vel_q   <= cfg_data_i[LW-1:0];
        jeag_pkg::CFG_SUSPENSION_MS:  susp_q      <= cfg_data_i[jeag_pkg::SUSP_WIDTH-1:0];
        jeag_pkg::CFG_UPPER_LIMIT:    upper_q     <= cfg_data_i[LW-1:0];
        jeag_pkg::CFG_LOWER_LIMIT:    lower_q     <= cfg_data_i[LW-1:0];
        // amplify fraction is not stored; nothing here depends on it
        default: ;
      endcase
    end
  end

  // pipe control
  logic               in_valid_q, out_valid_q, advance;
  jeag_pkg::tick_in_t in_q;
  jeag_pkg::tick_out_t out_q, out_d;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // joint state
  logic          moving_flex_q, moving_flex_d;
  logic          first_move_q, first_move_d;
  logic          torque_q, torque_d;
  logic [TW-1:0] rev_ms_q, rev_ms_d, en_ms_q, en_ms_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_flex_q <= 1'b0;
      first_move_q  <= 1'b1;
      torque_q      <= 1'b0;
      rev_ms_q      <= '0;
      en_ms_q       <= '0;
    end else if (advance) begin
      moving_flex_q <= moving_flex_d;
      first_move_q  <= first_move_d;
      torque_q      <= torque_d;
      rev_ms_q      <= rev_ms_d;
      en_ms_q       <= en_ms_d;
    end
  end

  // tick evaluation
  logic signed [VW:0]   vel, sv;
  logic        [VW:0]   speed;
  logic signed [CmpW-1:0] traj, pos;
  logic        [LW+6:0] max_x100;
  logic                 limit_on, over_limit, allow_flex, allow_ext, motion, flex;
  logic                 rev_over, en_over, trail;
  logic [TW-1:0]        rev_end, en_end;
  logic [VW-1:0]        goal;

  always_comb begin
    vel        = (VW+1)'(in_q.velocity);
    sv         = $signed({{(VW+1-LW){1'b0}}, start_vel_q});
    speed      = vel[VW] ? (VW+1)'(-vel) : vel;
    traj       = CmpW'(in_q.trajectory_position);
    pos        = CmpW'(in_q.present_position);
    max_x100   = (LW+7)'(max_vel_q) * (LW+7)'(100);
    limit_on   = max_x100 > ((LW+7)'(1) << FRAC_BITS);
    over_limit = limit_on && (speed > (VW+1)'(max_vel_q));
    allow_flex = (dir_mode_q == jeag_pkg::DIR_BOTH) || (dir_mode_q == jeag_pkg::DIR_FLEX_ONLY);
    allow_ext  = (dir_mode_q == jeag_pkg::DIR_BOTH) || (dir_mode_q == jeag_pkg::DIR_EXT_ONLY);
    motion     = ((vel > sv) && allow_flex) || ((vel < -sv) && allow_ext);
    flex       = !vel[VW];

    moving_flex_d = moving_flex_q;
    first_move_d  = first_move_q;
    torque_d      = torque_q;
    rev_ms_d      = rev_ms_q;
    en_ms_d       = en_ms_q;
    out_d         = '0;

    // a tick over the speed limit tracks no direction
    if (!over_limit && motion && (moving_flex_q != flex)) begin
      moving_flex_d = flex;
      if (first_move_q) begin
        first_move_d = 1'b0;
      end else begin
        rev_ms_d = in_q.now_ms;
      end
    end

    rev_end  = rev_ms_d + TW'(susp_q);
    en_end   = en_ms_q + TW'(susp_q);
    rev_over = rev_end < in_q.now_ms;
    en_over  = en_end < in_q.now_ms;
    trail    = moving_flex_d ? (traj > pos + Five) : (traj < pos - Five);
    goal     = moving_flex_d ? VW'(upper_q) : VW'(-(VW'(lower_q)));

    if (over_limit) begin
      torque_d = 1'b0;
    end else if (motion) begin
      if (moving_flex_q != flex) begin
        torque_d = 1'b0;
      end
      if (rev_over) begin
        if (!torque_d) begin
          torque_d          = 1'b1;
          out_d.drive_setup = 1'b1;
          out_d.goal_write  = 1'b1;
          en_ms_d           = in_q.now_ms;
        end
        if (trail) begin
          out_d.goal_write = 1'b1;
        end
      end
    end else if (en_over) begin
      torque_d = 1'b0;
    end

    out_d.torque_on     = torque_d;
    out_d.goal_position = out_d.goal_write ? goal : '0;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_setup_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.drive_setup |-> out_q.torque_on && out_q.goal_write)
    else $error("drive setup without torque on and goal write");

  a_goal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.goal_write |-> out_q.goal_position == '0)
    else $error("goal position nonzero without goal write");

  a_first_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_move_q |=> !first_move_q)
    else $error("first movement flag set again");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("pending input beat lost");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int VW             = jeag_pkg::VALUE_WIDTH;
  localparam int LW             = jeag_pkg::LIMIT_WIDTH;
  localparam int TW             = jeag_pkg::TIME_WIDTH;
  localparam int SW             = jeag_pkg::SUSP_WIDTH;
  localparam int MW             = jeag_pkg::DIR_WIDTH;
  localparam int IW             = jeag_pkg::CFG_IDX_W;
  localparam int CW             = jeag_pkg::CFG_DATA_W;
  localparam int FRAC_BITS      = 8;
  localparam longint FIVE_UNITS = longint'(5) << FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_LEN   = 64;
  localparam int PHASES         = 13;
  localparam int PHASE_ITEMS    = 125;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  jeag_pkg::tick_in_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  jeag_pkg::tick_out_t out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [IW-1:0]       cfg_index_i = '0;
  logic [CW-1:0]       cfg_data_i = '0;

  joint_effort_amplify_gate_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the registers and the joint state
  logic [MW-1:0] dir_mode  = jeag_pkg::DIR_BOTH;
  logic [LW-1:0] start_vel = '0;
  logic [LW-1:0] max_vel   = '0;
  logic [SW-1:0] susp_ms   = '0;
  logic [LW-1:0] upper_lim = '0;
  logic [LW-1:0] lower_lim = '0;

  logic          moving_flex  = 1'b0;
  logic          first_move   = 1'b1;
  logic [TW-1:0] reversal_ms  = '0;
  logic [TW-1:0] enable_ms    = '0;
  logic          torque_st    = 1'b0;

  jeag_pkg::tick_in_t  tick_backlog[$];
  jeag_pkg::tick_out_t predicted_outs[$];

  logic in_beat  = 1'b0;
  logic out_beat = 1'b0;
  int   mismatches = 0;
  int   idle_cycles = 0;

  // Stimulus walk state
  logic [TW-1:0] walk_now = '0;
  longint        walk_pos = 0;
  logic          walk_flex = 1'b1;

  function automatic logic window_passed(logic [TW-1:0] since, logic [TW-1:0] now);
    logic [TW-1:0] ends;
    ends = since + TW'(susp_ms);
    return ends < now;
  endfunction

  function automatic longint aimed_goal();
    return moving_flex ? longint'(upper_lim) : -longint'(lower_lim);
  endfunction

  function automatic jeag_pkg::tick_out_t gate_tick(jeag_pkg::tick_in_t t);
    longint              vel, traj, pos, speed, sv, goal;
    logic                allow_flex, allow_ext, limit_on, flex;
    jeag_pkg::tick_out_t r;
    r          = '0;
    goal       = 0;
    vel        = longint'(t.velocity);
    traj       = longint'(t.trajectory_position);
    pos        = longint'(t.present_position);
    speed      = (vel < 0) ? -vel : vel;
    sv         = longint'(start_vel);
    allow_flex = (dir_mode == jeag_pkg::DIR_BOTH) || (dir_mode == jeag_pkg::DIR_FLEX_ONLY);
    allow_ext  = (dir_mode == jeag_pkg::DIR_BOTH) || (dir_mode == jeag_pkg::DIR_EXT_ONLY);
    // limit engages only above 0.01
    limit_on   = (longint'(max_vel) * 100) > (longint'(1) << FRAC_BITS);
    if (speed > longint'(max_vel) && limit_on) begin
      torque_st = 1'b0;
    end else if ((vel > sv && allow_flex) || (vel < -sv && allow_ext)) begin
      flex = vel > 0;
      if (moving_flex != flex) begin
        moving_flex = flex;
        if (first_move) first_move = 1'b0;
        else reversal_ms = t.now_ms;
        torque_st = 1'b0;
      end
      if (window_passed(reversal_ms, t.now_ms)) begin
        if (!torque_st) begin
          torque_st     = 1'b1;
          r.drive_setup = 1'b1;
          r.goal_write  = 1'b1;
          goal          = aimed_goal();
          enable_ms     = t.now_ms;
        end
        if (moving_flex ? (traj > pos + FIVE_UNITS) : (traj < pos - FIVE_UNITS)) begin
          r.goal_write = 1'b1;
          goal         = aimed_goal();
        end
      end
    end else if (window_passed(enable_ms, t.now_ms)) begin
      torque_st = 1'b0;
    end
    r.torque_on = torque_st;
    if (r.goal_write) r.goal_position = goal[VW-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Monitor: sample handshakes, predict on input beats, check output beats
  always @(posedge clk_i) begin
    jeag_pkg::tick_out_t want;
    in_beat  = rst_ni && in_valid_i && in_ready_o;
    out_beat = rst_ni && out_valid_o && out_ready_i;
    if (out_beat) begin
      if (predicted_outs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
      end else begin
        want = predicted_outs.pop_front();
        check_field("torque_on", 32'(want.torque_on), 32'(out_data_o.torque_on));
        check_field("drive_setup", 32'(want.drive_setup), 32'(out_data_o.drive_setup));
        check_field("goal_write", 32'(want.goal_write), 32'(out_data_o.goal_write));
        check_field("goal_position", 32'(want.goal_position),
                    32'(out_data_o.goal_position));
      end
    end
    if (in_beat) predicted_outs.push_back(gate_tick(in_data_i));
    if (in_beat || out_beat) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("joint_effort_amplify_gate_core: mismatch");
      $finish;
    end
  end

  // Driver: bursts of beats with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (in_valid_i && !in_beat) begin
      // hold the offered beat
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i <= 1'b0;
    end else if (rst_ni && tick_backlog.size() > 0) begin
      in_valid_i <= 1'b1;
      in_data_i  <= tick_backlog.pop_front();
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: stall patterns that change over time, plus periodic long hold-offs
  int rx_cycles = 0;
  int rx_mode   = 0;
  int hold_left = 0;

  always @(negedge clk_i) begin
    logic rdy;
    rx_cycles++;
    if (rx_cycles % 200 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (rx_cycles % 1500 == 700) begin
      hold_left = HOLD_OFF_LEN;
      rdy       = 1'b0;
    end else begin
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = (rx_cycles % 4 == 0);
        default: rdy = ($urandom_range(0, 9) != 0);
      endcase
    end
    out_ready_i <= rdy;
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      jeag_pkg::CFG_DIRECTION_MODE: dir_mode  = data[MW-1:0];
      jeag_pkg::CFG_START_VELOCITY: start_vel = data;
      jeag_pkg::CFG_MAX_VELOCITY:   max_vel   = data;
      jeag_pkg::CFG_SUSPENSION_MS:  susp_ms   = data[SW-1:0];
      jeag_pkg::CFG_UPPER_LIMIT:    upper_lim = data;
      jeag_pkg::CFG_LOWER_LIMIT:    lower_lim = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [9:0] amp, logic [MW-1:0] mode,
                           logic [LW-1:0] sv, logic [LW-1:0] mx,
                           logic [SW-1:0] su, logic [LW-1:0] up,
                           logic [LW-1:0] lo);
    write_reg(jeag_pkg::CFG_AMPLIFY_FRACTION, CW'(amp));
    write_reg(jeag_pkg::CFG_DIRECTION_MODE, CW'(mode));
    write_reg(jeag_pkg::CFG_START_VELOCITY, sv);
    write_reg(jeag_pkg::CFG_MAX_VELOCITY, mx);
    write_reg(jeag_pkg::CFG_SUSPENSION_MS, CW'(su));
    write_reg(jeag_pkg::CFG_UPPER_LIMIT, up);
    write_reg(jeag_pkg::CFG_LOWER_LIMIT, lo);
    cfg_we_i <= 1'b0;
  endtask

  // Drain: nothing pending, nothing offered, nothing outstanding
  task automatic wait_drained();
    while (tick_backlog.size() != 0 || in_valid_i || predicted_outs.size() != 0) begin
      @(negedge clk_i);
      // let the driver's update of the offered beat settle
      #1;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_tick(longint vel, logic [TW-1:0] now, longint traj, longint pos);
    jeag_pkg::tick_in_t t;
    t.velocity            = vel[VW-1:0];
    t.now_ms              = now;
    t.trajectory_position = traj[VW-1:0];
    t.present_position    = pos[VW-1:0];
    tick_backlog.push_back(t);
  endtask

  // Plausible motion: slowly advancing time, direction flipped at random, lead near 5, plus random ticks
  task automatic queue_motion(int n);
    longint             mag, traj, step, sv, mx;
    int                 pick;
    jeag_pkg::tick_in_t t;
    sv = longint'(start_vel);
    mx = longint'(max_vel);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) begin
        t.velocity            = VW'($urandom);
        t.now_ms              = $urandom;
        t.trajectory_position = VW'($urandom);
        t.present_position    = VW'($urandom);
        tick_backlog.push_back(t);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) step = 0;
        else if (pick < 85) step = longint'($urandom_range(1, 25));
        else if (pick < 95) step = longint'($urandom_range(26, 300));
        else step = longint'($urandom_range(301, 70000));
        walk_now = walk_now + step[TW-1:0];
        case ($urandom_range(0, 9))
          0, 1, 2, 3: mag = sv + 1 + longint'($urandom_range(0, 400));
          4:          mag = sv;
          5:          mag = sv + 1;
          6:          mag = mx + longint'($urandom_range(0, 1));
          7:          mag = longint'($urandom_range(0, int'(sv)));
          8:          mag = 0;
          default:    mag = longint'($urandom_range(0, 8388607));
        endcase
        if (mag > 8388607) mag = 8388607;
        if ($urandom_range(0, 9) < 3) walk_flex = !walk_flex;
        walk_pos = walk_pos + longint'($urandom_range(0, 1000)) - 500;
        if (walk_pos > 8000000 || walk_pos < -8000000) walk_pos = 0;
        case ($urandom_range(0, 9))
          0:          traj = walk_pos + FIVE_UNITS;
          1:          traj = walk_pos + FIVE_UNITS + 1;
          2:          traj = walk_pos + FIVE_UNITS - 1;
          3:          traj = walk_pos - FIVE_UNITS;
          4:          traj = walk_pos - FIVE_UNITS - 1;
          5:          traj = walk_pos - FIVE_UNITS + 1;
          6, 7, 8:    traj = walk_pos + longint'($urandom_range(0, 6000)) - 3000;
          default:    traj = longint'($urandom);
        endcase
        push_tick(walk_flex ? mag : -mag, walk_now, traj, walk_pos);
      end
    end
  endtask

  initial begin
    logic [LW-1:0] sv, mx, up, lo;
    logic [SW-1:0] su;
    logic [MW-1:0] mode;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings: zero speed, first move as extension, wrap of time
    push_tick(0, 0, 0, 0);
    push_tick(-1, 1, 0, 0);
    push_tick(-8388608, 2, -8388608, 8388607);
    push_tick(8388607, 3, 8388607, -8388608);
    push_tick(-5, 4, 0, 0);
    push_tick(-5, 5, -FIVE_UNITS - 1, 0);
    push_tick(-5, 6, -FIVE_UNITS, 0);
    push_tick(0, 7, 0, 0);
    push_tick(5, 32'hFFFF_FFFF, FIVE_UNITS + 1, 0);
    push_tick(5, 32'h0000_0000, FIVE_UNITS + 1, 0);
    wait_drained();

    // Flexion only, limit at 0.008 (inactive), window wraps past 2^32
    write_all(10'd1023, jeag_pkg::DIR_FLEX_ONLY, 23'd100, 23'd2, 16'hFFFF, 23'h7FFFFF,
              23'h7FFFFF);
    push_tick(101, 32'hFFFF_FF00, FIVE_UNITS + 1, 0);
    push_tick(100, 32'hFFFF_FF01, 0, 0);
    push_tick(-101, 32'hFFFF_FF02, 0, 0);
    push_tick(8388607, 32'hFFFF_FF03, 8388607, -8388608);
    wait_drained();

    // No direction allowed, limit at 0.012 (active)
    write_reg(jeag_pkg::CFG_DIRECTION_MODE, CW'(jeag_pkg::DIR_NONE));
    write_reg(jeag_pkg::CFG_MAX_VELOCITY, 23'd3);
    cfg_we_i <= 1'b0;
    push_tick(4, 100, 0, 0);
    push_tick(-8388608, 101, 0, 0);
    push_tick(3, 102, 0, 0);
    push_tick(200, 103, 0, 0);
    wait_drained();

    // Extension only: reversal after first movement, then flexion is ignored
    write_all(10'd1, jeag_pkg::DIR_EXT_ONLY, 23'd0, 23'd0, 16'd0, 23'd0, 23'd1000);
    push_tick(-1, 1000, -2000, 0);
    push_tick(-1, 1001, -2000, 0);
    push_tick(1, 1002, 0, 0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        write_all(10'd1, jeag_pkg::DIR_BOTH, '0, '0, '0, '0, '0);
      end else if (p == 1) begin
        write_all(10'd1023, jeag_pkg::DIR_BOTH, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF,
                  23'h7FFFFF, 23'h7FFFFF);
      end else begin
        case ($urandom_range(0, 3))
          0:       sv = '0;
          1, 2:    sv = LW'($urandom_range(0, 2000));
          default: sv = LW'($urandom_range(0, 8388607));
        endcase
        case ($urandom_range(0, 5))
          0:       mx = '0;
          1:       mx = LW'($urandom_range(1, 3));
          2, 3:    mx = LW'(sv + $urandom_range(0, 3000));
          default: mx = LW'($urandom_range(0, 8388607));
        endcase
        case ($urandom_range(0, 5))
          0:       su = '0;
          1, 2, 3: su = SW'($urandom_range(1, 40));
          4:       su = SW'($urandom_range(41, 400));
          default: su = 16'hFFFF;
        endcase
        case ($urandom_range(0, 5))
          1:       mode = jeag_pkg::DIR_FLEX_ONLY;
          2:       mode = jeag_pkg::DIR_EXT_ONLY;
          3:       mode = jeag_pkg::DIR_NONE;
          default: mode = jeag_pkg::DIR_BOTH;
        endcase
        up = ($urandom_range(0, 1) == 0) ? LW'($urandom_range(0, 8388607))
                                         : LW'($urandom_range(0, 5000));
        lo = ($urandom_range(0, 1) == 0) ? LW'($urandom_range(0, 8388607))
                                         : LW'($urandom_range(0, 5000));
        write_all(10'($urandom_range(1, 1023)), mode, sv, mx, su, up, lo);
      end
      // start some phases just short of the 32-bit time wrap
      walk_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400)
                                             : $urandom;
      queue_motion(PHASE_ITEMS);
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("joint_effort_amplify_gate_core: match");
    end else begin
      $display("joint_effort_amplify_gate_core: mismatch");
    end
    $finish;
  end

endmodule
